// ===== sv/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  // Hue arithmetic, in 1/64-degree units
  localparam logic [14:0] HUE_FULL    = 15'd23040;  // 360 degrees
  localparam logic [11:0] SECTOR_SPAN = 12'd3840;   // 60 degrees
  localparam int          SECTORS     = 6;

  // 8-bit fraction full scale
  localparam logic [7:0]  FULL_SCALE  = 8'd255;

  // Secondary channel divide: floor(P / (255*3840)) = floor((P >> 8) / 3825)
  localparam logic [19:0] X_DIV       = 20'd3825;
  localparam logic [18:0] X_RECIP     = 19'd280716;  // floor(2^30 / 3825)
  localparam int          X_SHIFT     = 30;

  // Sector codes, 60 degrees each
  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
  localparam logic [2:0] SEC_MAG_RED  = 3'd5;

  // Beat passed from the hue/saturation front end to the scaling back end
  typedef struct packed {
    logic [2:0]  sector;
    logic [19:0] weight;     // s*k + (255-s)*3840
    logic [15:0] zero_num;   // v*(255-s)
    logic [7:0]  val;        // brightness
  } front_t;

endpackage

// ===== sv/hsv2rgb_front.sv =====
module hsv2rgb_front (
  input  logic                 clk,
  input  logic [1:0]           en,
  input  logic [14:0]          hue,
  input  logic [7:0]           saturation,
  input  logic [7:0]           brightness,
  output hsv2rgb_pkg::front_t  beat
);

  // stage 1 registers
  logic [2:0]  s1_sector;
  logic [11:0] s1_frac;
  logic [7:0]  s1_sat;
  logic [7:0]  s1_val;

  logic [14:0] hue_wrap;
  logic [2:0]  sector_c;
  logic [14:0] frac_c;

  // Wrap hue into one turn, then find the 60-degree sector and offset in it
  always_comb begin
    hue_wrap = (hue >= hsv2rgb_pkg::HUE_FULL) ? hue - hsv2rgb_pkg::HUE_FULL : hue;
    sector_c = 3'd0;
    for (int i = 1; i < hsv2rgb_pkg::SECTORS; i++) begin
      if (hue_wrap >= 15'(i) * 15'(hsv2rgb_pkg::SECTOR_SPAN)) begin
        sector_c = 3'(i);
      end
    end
    frac_c = hue_wrap - 15'(sector_c) * 15'(hsv2rgb_pkg::SECTOR_SPAN);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sector <= sector_c;
      s1_frac   <= frac_c[11:0];
      s1_sat    <= saturation;
      s1_val    <= brightness;
    end
  end

  // Stage 2: ramp position k (falling in odd sectors) and the two numerators
  logic [11:0] ramp;
  logic [7:0]  sat_inv;
  logic [19:0] weight_c;
  logic [15:0] zero_c;

  always_comb begin
    ramp     = s1_sector[0] ? hsv2rgb_pkg::SECTOR_SPAN - s1_frac : s1_frac;
    sat_inv  = hsv2rgb_pkg::FULL_SCALE - s1_sat;
    weight_c = 20'(s1_sat) * 20'(ramp) + 20'(sat_inv) * 20'(hsv2rgb_pkg::SECTOR_SPAN);
    zero_c   = 16'(s1_val) * 16'(sat_inv);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      beat.sector   <= s1_sector;
      beat.weight   <= weight_c;
      beat.zero_num <= zero_c;
      beat.val      <= s1_val;
    end
  end

endmodule

// ===== sv/hsv2rgb_scale.sv =====
module hsv2rgb_scale (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  hsv2rgb_pkg::front_t  beat,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);

  // Stage 3: full secondary numerator v*w, and n*257 for the divide by 255
  logic [2:0]  s3_sector;
  logic [27:0] s3_prod;
  logic [23:0] s3_zq;
  logic [15:0] s3_znum;
  logic [7:0]  s3_val;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s3_sector <= beat.sector;
      s3_prod   <= 28'(beat.val) * 28'(beat.weight);
      s3_zq     <= {beat.zero_num, 8'd0} + 24'(beat.zero_num);
      s3_znum   <= beat.zero_num;
      s3_val    <= beat.val;
    end
  end

  // Stage 4: reciprocal multiply for X, finish the zero channel
  logic [7:0]  zq_est;
  logic [15:0] z_rem;
  logic [7:0]  zero_c;

  always_comb begin
    zq_est = s3_zq[23:16];
    z_rem  = s3_znum - 16'(zq_est) * 16'(hsv2rgb_pkg::FULL_SCALE);
    zero_c = (z_rem >= 16'(hsv2rgb_pkg::FULL_SCALE)) ? zq_est + 8'd1 : zq_est;
  end

  logic [2:0]  s4_sector;
  logic [38:0] s4_recip;
  logic [19:0] s4_num;
  logic [7:0]  s4_zero;
  logic [7:0]  s4_val;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s4_sector <= s3_sector;
      s4_recip  <= 39'(s3_prod[27:8]) * 39'(hsv2rgb_pkg::X_RECIP);
      s4_num    <= s3_prod[27:8];
      s4_zero   <= zero_c;
      s4_val    <= s3_val;
    end
  end

  // Stage 5: one-step correction of the X estimate, then place channels
  logic [7:0]  xq_est;
  logic [19:0] x_rem;
  logic [7:0]  sec_c;
  logic [7:0]  red_c;
  logic [7:0]  green_c;
  logic [7:0]  blue_c;

  always_comb begin
    xq_est = s4_recip[hsv2rgb_pkg::X_SHIFT +: 8];
    x_rem  = s4_num - 20'(xq_est) * hsv2rgb_pkg::X_DIV;
    sec_c  = (x_rem >= hsv2rgb_pkg::X_DIV) ? xq_est + 8'd1 : xq_est;
    case (s4_sector)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        red_c = s4_val;  green_c = sec_c;   blue_c = s4_zero;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        red_c = sec_c;   green_c = s4_val;  blue_c = s4_zero;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        red_c = s4_zero; green_c = s4_val;  blue_c = sec_c;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        red_c = s4_zero; green_c = sec_c;   blue_c = s4_val;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        red_c = sec_c;   green_c = s4_zero; blue_c = s4_val;
      end
      default: begin
        red_c = s4_val;  green_c = s4_zero; blue_c = sec_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      red   <= red_c;
      green <= green_c;
      blue  <= blue_c;
    end
  end

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// Channel  Direction  Handshake              Payload
// hsv      in         hsv_valid / hsv_stall  hue[14:0], saturation[7:0], brightness[7:0]
// rgb      out        rgb_valid / rgb_stall  red[7:0], green[7:0], blue[7:0]
//
// Five register stages; a beat enters every cycle unless hsv_stall holds it.
// The depth is set by the two chained multiplies (v*w, then the reciprocal of
// 3825) and the one-step correction of the X quotient, each with a stage of its own.
// Reset clears the stage valid bits only; data registers are not reset.
// Each stage holds only when it is full and the stage after it holds, so
// empty stages close up under an rgb stall; hsv_stall rises only when stage 1
// is full and blocked.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        hsv_valid,
  output logic        hsv_stall,
  input  logic [14:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        rgb_valid,
  input  logic        rgb_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  logic [4:0] vld;
  logic [4:0] en;

  hsv2rgb_pkg::front_t front_beat;

  // Stage enables: a stage loads when it is empty or its contents move on
  always_comb begin
    en[4] = !vld[4] || !rgb_stall;
    for (int i = 3; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign hsv_stall = !en[0];
  assign rgb_valid = vld[4];

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= hsv_valid;
      end
      for (int i = 1; i < 5; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  hsv2rgb_front u_front (
    .clk        (clk),
    .en         (en[1:0]),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .beat       (front_beat)
  );

  hsv2rgb_scale u_scale (
    .clk   (clk),
    .en    (en[4:2]),
    .beat  (front_beat),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  // Stall upstream only when stage 1 is actually occupied
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> vld[0])
    else $error("hsv_stall raised with stage 1 empty");

  // An accepted beat lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall) |=> vld[0])
    else $error("accepted beat lost at stage 1");

  // A blocked middle stage keeps its beat
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && !en[3]) |=> vld[2])
    else $error("stage 3 beat dropped while blocked");

  // Output drains when taken and nothing follows
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && !rgb_stall && !vld[3]) |=> !rgb_valid)
    else $error("rgb beat repeated after being taken");

endmodule
